// ----- design/sotc_pkg.sv -----
// Shared types and constants of the sorted-table occurrence counter.
`timescale 1ns / 1ps

package sotc_pkg;

    // Default table depth.
    localparam int TABLE_DEPTH_DEF = 1024;

    // Width of a table entry and of a request value.
    localparam int VALUE_W = 32;

    // Width of the index and count fields in a result.
    localparam int OUT_W = 11;

    // Width of the running total.
    localparam int TOTAL_W = 48;

    // Internal index and count width wide enough for the deepest table (65536 entries).
    localparam int RES_W = 17;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Search sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COUNT,
        S_REPORT
    } t_state;

    // Controls of one bound search engine.
    typedef struct packed {
        logic init;
        logic issue;
        logic cmp;
    } t_bound_ctl;

    // Outcome of one query, handed from the sequencer to the top level.
    typedef struct packed {
        logic             found;
        logic [RES_W-1:0] first;
        logic [RES_W-1:0] count;
    } t_search_res;

endpackage

// ----- design/sotc_table.sv -----
// Table memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module sotc_table import sotc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic signed [VALUE_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic signed [VALUE_W-1:0] o_rd_data
);

    logic signed [VALUE_W-1:0] r_mem [TABLE_DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- design/sotc_bound.sv -----
// One binary search engine for the first or the last occurrence of a key.
`timescale 1ns / 1ps

module sotc_bound import sotc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter bit LEFTMOST    = 1'b1,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_bound_ctl                i_ctl,
    input  logic [CW-1:0]             i_n,
    input  logic signed [VALUE_W-1:0] i_key,
    input  logic signed [VALUE_W-1:0] i_rdata,
    output logic [AW-1:0]             o_addr,
    output logic                      o_active,
    output logic                      o_pend,
    output logic [CW-1:0]             o_hit
);

    // The window is [r_lo, r_hp): r_hp is one past the last candidate.
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hp;
    logic [CW-1:0] r_hit;
    logic [AW-1:0] r_mid;
    logic          r_pend;
    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid_ext;
    logic [CW-1:0] w_mid_inc;

    // Midpoint of the window, rounded down; only used while the window is non-empty.
    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hp} - (CW + 1)'(1);
    assign o_addr    = w_sum[AW:1];
    assign w_mid_ext = CW'(r_mid);
    assign w_mid_inc = w_mid_ext + CW'(1);

    assign o_active = (r_lo < r_hp);
    assign o_pend   = r_pend;
    assign o_hit    = r_hit;

    // A probe is outstanding between its issue and its compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_ctl.init) begin
            r_pend <= 1'b0;
        end else if (i_ctl.issue) begin
            r_pend <= 1'b1;
        end else if (i_ctl.cmp) begin
            r_pend <= 1'b0;
        end
    end

    // Window update from the entry that the probe returned.
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_lo  <= '0;
            r_hp  <= i_n;
            r_hit <= i_n;
        end else if (i_ctl.issue) begin
            r_mid <= o_addr;
        end else if (i_ctl.cmp) begin
            if (i_rdata == i_key) begin
                r_hit <= w_mid_ext;
                if (LEFTMOST) begin
                    r_hp <= w_mid_ext;
                end else begin
                    r_lo <= w_mid_inc;
                end
            end else if (i_rdata > i_key) begin
                r_hp <= w_mid_ext;
            end else begin
                r_lo <= w_mid_inc;
            end
        end
    end

endmodule

// ----- design/sotc_search.sv -----
// Query sequencer: runs the two bound searches interleaved on one read port.
`timescale 1ns / 1ps

module sotc_search import sotc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [VALUE_W-1:0] i_key,
    input  logic [CW-1:0]             i_n,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    input  logic signed [VALUE_W-1:0] i_rdata,
    output logic                      o_busy,
    output logic                      o_done,
    output t_search_res               o_res
);

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_turn;
    logic signed [VALUE_W-1:0] r_key;
    logic [CW-1:0]             r_n;
    t_search_res               r_res;
    t_bound_ctl                w_ctl_first;
    t_bound_ctl                w_ctl_last;
    logic [AW-1:0]             w_addr_first;
    logic [AW-1:0]             w_addr_last;
    logic                      w_act_first;
    logic                      w_act_last;
    logic                      w_pend_first;
    logic                      w_pend_last;
    logic [CW-1:0]             w_hit_first;
    logic [CW-1:0]             w_hit_last;
    logic                      w_found;
    logic                      w_settled;

    // Search for the first occurrence.
    sotc_bound #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LEFTMOST    (1'b1)
    ) u_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_first),
        .i_n      (i_n),
        .i_key    (r_key),
        .i_rdata  (i_rdata),
        .o_addr   (w_addr_first),
        .o_active (w_act_first),
        .o_pend   (w_pend_first),
        .o_hit    (w_hit_first)
    );

    // Search for the last occurrence.
    sotc_bound #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LEFTMOST    (1'b0)
    ) u_last (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl_last),
        .i_n      (i_n),
        .i_key    (r_key),
        .i_rdata  (i_rdata),
        .o_addr   (w_addr_last),
        .o_active (w_act_last),
        .o_pend   (w_pend_last),
        .o_hit    (w_hit_last)
    );

    // Both searches have converged and no probe is outstanding.
    assign w_settled = !w_act_first && !w_act_last && !w_pend_first && !w_pend_last;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_settled) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs: in each search cycle one engine issues and the other compares.
    always_comb begin
        w_ctl_first       = '0;
        w_ctl_last        = '0;
        w_ctl_first.init  = (r_state == S_IDLE) && i_start;
        w_ctl_last.init   = (r_state == S_IDLE) && i_start;
        w_ctl_first.issue = (r_state == S_SEARCH) && !r_turn && w_act_first;
        w_ctl_first.cmp   = (r_state == S_SEARCH) && r_turn && w_pend_first;
        w_ctl_last.issue  = (r_state == S_SEARCH) && r_turn && w_act_last;
        w_ctl_last.cmp    = (r_state == S_SEARCH) && !r_turn && w_pend_last;
        o_rd_en           = w_ctl_first.issue || w_ctl_last.issue;
        o_rd_addr         = r_turn ? w_addr_last : w_addr_first;
        o_busy            = (r_state != S_IDLE);
        o_done            = (r_state == S_REPORT);
    end

    // State register and turn bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_turn  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SEARCH) begin
                r_turn <= !r_turn;
            end else begin
                r_turn <= 1'b0;
            end
        end
    end

    // Query key and entry count held for the whole search.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_key <= i_key;
            r_n   <= i_n;
        end
    end

    // Outcome of both searches.
    assign w_found = (w_hit_first != r_n) && (w_hit_last != r_n);

    always_ff @(posedge i_clk) begin
        if (r_state == S_COUNT) begin
            r_res.found <= w_found;
            r_res.first <= RES_W'(w_hit_first);
            if (w_found && (w_hit_last >= w_hit_first)) begin
                r_res.count <= RES_W'(w_hit_last - w_hit_first + CW'(1));
            end else begin
                r_res.count <= '0;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- design/sorted_table_occurrence_counter.sv -----
// Top level of the sorted-table occurrence counter.
//
//  Channel   Ports                                              Direction
//  request   start, busy, i_operation, i_value                  in (busy out)
//  result    o_valid, o_found, o_first_index, o_match_count,    out
//            o_running_total
//
// A request is taken when start is high and busy is low. Loads and clears never
// raise busy. A query raises busy until its result is ready: the two searches
// share the single table read port, each probe waiting for the registered read
// data. The result shows for one cycle with o_valid, rising at the same edge at
// which busy falls; the receiver cannot stall it. Synchronous reset empties the
// table and clears the total at once; no clearing pass is needed, as entries are
// only read below the entry count.
`timescale 1ns / 1ps

module sorted_table_occurrence_counter import sotc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_operation,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    output logic                      o_found,
    output logic [OUT_W-1:0]          o_first_index,
    output logic [OUT_W-1:0]          o_match_count,
    output logic [TOTAL_W-1:0]        o_running_total
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0]             r_count;
    logic [TOTAL_W-1:0]        r_total;
    logic                      w_accept;
    logic                      w_load;
    logic                      w_query;
    logic                      w_clear;
    logic                      w_full;
    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic signed [VALUE_W-1:0] w_rdata;
    logic                      w_done;
    t_search_res               w_res;
    logic [TOTAL_W:0]          w_sum;
    logic [TOTAL_W-1:0]        w_total_next;

    // Request decode.
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(TABLE_DEPTH));

    always_comb begin
        w_load  = 1'b0;
        w_query = 1'b0;
        w_clear = 1'b0;
        unique case (i_operation)
            OP_LOAD:  w_load  = w_accept;
            OP_QUERY: w_query = w_accept;
            OP_CLEAR: w_clear = w_accept;
            default: begin
                w_load  = 1'b0;
                w_query = 1'b0;
                w_clear = 1'b0;
            end
        endcase
    end

    sotc_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_load && !w_full),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rdata)
    );

    sotc_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_query),
        .i_key     (i_value),
        .i_n       (r_count),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rdata   (w_rdata),
        .o_busy    (busy),
        .o_done    (w_done),
        .o_res     (w_res)
    );

    // Saturating running total.
    assign w_sum        = {1'b0, r_total} + (TOTAL_W + 1)'(w_res.count);
    assign w_total_next = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];

    // Entry count, total and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_done;
            if (w_clear) begin
                r_count <= '0;
                r_total <= '0;
            end else begin
                if (w_load && !w_full) begin
                    r_count <= r_count + CW'(1);
                end
                if (w_done) begin
                    r_total <= w_total_next;
                end
            end
        end
    end

    // Result fields.
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            o_found         <= w_res.found;
            o_first_index   <= OUT_W'(w_res.first);
            o_match_count   <= OUT_W'(w_res.count);
            o_running_total <= w_total_next;
        end
    end

    // A result strobe only follows the end of a search.
    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_done))
        else $error("result strobe without a finished search");

    // The entry count never passes the table depth.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A load into a table with room advances the entry count by one.
    a_load_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("load did not advance the entry count");

    // The table is never read outside a query search.
    a_read_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (busy && !w_done))
        else $error("table read outside a search");

endmodule

// ----- test/tb_sorted_table_occurrence_counter.sv -----
// Self-checking testbench for the sorted-table occurrence counter with its own lookup predictor.
`timescale 1ns / 1ps

module tb_sorted_table_occurrence_counter;
    import sotc_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam longint unsigned TOTAL_MAX = 48'hffff_ffff_ffff;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic               found;
        logic [OUT_W-1:0]   first_index;
        logic [OUT_W-1:0]   match_count;
        logic [TOTAL_W-1:0] running_total;
    } t_lookup;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                i_operation = OP_LOAD;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic                      o_found;
    logic [OUT_W-1:0]          o_first_index;
    logic [OUT_W-1:0]          o_match_count;
    logic [TOTAL_W-1:0]        o_running_total;

    // Requests still to be presented, and lookups whose results are still due.
    t_request requests_to_send[$];
    t_lookup  awaited_results[$];

    // Predictor state: table contents, entry count and saturating total.
    logic signed [VALUE_W-1:0] model_table [TABLE_DEPTH];
    int                        model_entries = 0;
    longint unsigned           model_total = 0;

    // Values loaded so far as the stimulus is built, used to aim queries at real entries.
    logic signed [VALUE_W-1:0] loaded_keys[$];

    int failures = 0;
    int burst_left = 0;
    int gap_left = 0;
    t_request next_req;

    sorted_table_occurrence_counter #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_first_index  (o_first_index),
        .o_match_count  (o_match_count),
        .o_running_total(o_running_total)
    );

    always #4 i_clk = ~i_clk;

    // Binary search for the first or the last entry equal to the key; the entry count if none.
    function automatic int bound_search(input logic signed [VALUE_W-1:0] key, input bit leftmost);
        int lo;
        int hi;
        int hit;
        int mid;
        lo = 0;
        hi = model_entries - 1;
        hit = model_entries;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (model_table[mid] == key) begin
                hit = mid;
                if (leftmost) hi = mid - 1;
                else lo = mid + 1;
            end else if (model_table[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return hit;
    endfunction

    // Applies one accepted request to the predictor and records the lookup result it is due.
    task automatic track_request(input t_request req);
        int first;
        int last;
        longint unsigned cnt;
        bit hit;
        t_lookup res;
        case (req.op)
            OP_LOAD: begin
                if (model_entries < TABLE_DEPTH) begin
                    model_table[model_entries] = req.value;
                    model_entries++;
                end
            end
            OP_CLEAR: begin
                model_entries = 0;
                model_total = 0;
            end
            OP_QUERY: begin
                first = bound_search(req.value, 1'b1);
                last = bound_search(req.value, 1'b0);
                hit = (first != model_entries) && (last != model_entries);
                cnt = 0;
                if (hit && last >= first) begin
                    cnt = longint'(last - first) + 1;
                    if (model_total > TOTAL_MAX - cnt) model_total = TOTAL_MAX;
                    else model_total += cnt;
                end
                res.found = hit;
                res.first_index = first[OUT_W-1:0];
                res.match_count = cnt[OUT_W-1:0];
                res.running_total = model_total[TOTAL_W-1:0];
                awaited_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Queues one request and keeps the record of loaded values in step.
    task automatic add_request(input logic [1:0] op, input logic signed [VALUE_W-1:0] value);
        t_request req;
        req.op = op;
        req.value = value;
        requests_to_send.push_back(req);
        if (op == OP_LOAD && loaded_keys.size() < TABLE_DEPTH) loaded_keys.push_back(value);
        if (op == OP_CLEAR) loaded_keys.delete();
    endtask

    // Loads a run of non-decreasing values with a random base and spread.
    task automatic add_sorted_run(input int k);
        longint v;
        int shift;
        v = ($urandom_range(0, 7) == 0) ? longint'(VALUE_MIN) : longint'($signed($urandom));
        shift = $urandom_range(0, 31);
        for (int i = 0; i < k; i++) begin
            add_request(OP_LOAD, v[VALUE_W-1:0]);
            if ($urandom_range(0, 2) != 0) v += longint'($urandom >> shift);
            if (v > longint'(VALUE_MAX)) v = longint'(VALUE_MAX);
        end
    endtask

    // Query key: mostly a loaded value or a neighbour of one, sometimes anything at all.
    function automatic logic signed [VALUE_W-1:0] pick_key();
        logic signed [VALUE_W-1:0] key;
        if (loaded_keys.size() == 0 || $urandom_range(0, 4) == 0) return $urandom;
        key = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
        case ($urandom_range(0, 5))
            0: key = key + 1;
            1: key = key - 1;
            default: ;
        endcase
        return key;
    endfunction

    // Driver: presents requests in bursts with random gaps and follows the predictor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_operation <= OP_LOAD;
            i_value <= '0;
        end else begin
            if (start && !busy) track_request('{op: i_operation, value: i_value});
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (requests_to_send.size() > 0) begin
                    next_req = requests_to_send.pop_front();
                    start <= 1'b1;
                    i_operation <= next_req.op;
                    i_value <= next_req.value;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 23);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        failures++;
    endtask

    // Monitor: compares every result strobe with the oldest awaited lookup.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with no query waiting, expected none, actual first %0d",
                         $time, o_first_index);
                failures++;
            end else begin
                if (o_found !== awaited_results[0].found)
                    note_mismatch("found", awaited_results[0].found, o_found);
                if (o_first_index !== awaited_results[0].first_index)
                    note_mismatch("first_index", awaited_results[0].first_index, o_first_index);
                if (o_match_count !== awaited_results[0].match_count)
                    note_mismatch("match_count", awaited_results[0].match_count, o_match_count);
                if (o_running_total !== awaited_results[0].running_total)
                    note_mismatch("running_total", awaited_results[0].running_total,
                                  o_running_total);
                void'(awaited_results.pop_front());
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int count;
        int k;
        int nq;
        logic signed [VALUE_W-1:0] key;

        // Query on an empty table.
        add_request(OP_QUERY, 32'sd0);
        // Sorted table with both value extremes and a run of duplicates.
        add_request(OP_LOAD, VALUE_MIN);
        add_request(OP_LOAD, -32'sd5);
        add_request(OP_LOAD, -32'sd5);
        add_request(OP_LOAD, -32'sd5);
        add_request(OP_LOAD, 32'sd0);
        add_request(OP_LOAD, 32'sd7);
        add_request(OP_LOAD, VALUE_MAX);
        add_request(OP_QUERY, VALUE_MIN);
        add_request(OP_QUERY, -32'sd5);
        add_request(OP_QUERY, 32'sd0);
        add_request(OP_QUERY, VALUE_MAX);
        add_request(OP_QUERY, 32'sd3);
        add_request(OP_QUERY, -32'sd100);
        add_request(OP_QUERY, 32'sd100);
        // The unused operation code must give no result.
        add_request(OP_UNUSED, -32'sd5);
        // After a clear the old entries must not be seen.
        add_request(OP_CLEAR, 32'sd0);
        add_request(OP_QUERY, -32'sd5);
        // Unsorted table: the searches run on whatever is stored.
        add_request(OP_LOAD, 32'sd9);
        add_request(OP_LOAD, 32'sd1);
        add_request(OP_LOAD, 32'sd5);
        add_request(OP_QUERY, 32'sd1);
        add_request(OP_QUERY, 32'sd5);
        add_request(OP_CLEAR, VALUE_MAX);

        // Random sequences: mostly clear, sorted loads and queries aimed at the entries.
        count = 0;
        while (count < 200) begin
            if ($urandom_range(0, 4) != 0) begin
                add_request(OP_CLEAR, $urandom);
                count++;
            end
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
            if ($urandom_range(0, 7) == 0) begin
                for (int i = 0; i < k; i++) add_request(OP_LOAD, $urandom);
            end else begin
                add_sorted_run(k);
            end
            nq = $urandom_range(1, 10);
            for (int i = 0; i < nq; i++) add_request(OP_QUERY, pick_key());
            if ($urandom_range(0, 15) == 0) add_request(OP_UNUSED, $urandom);
            count += k + nq;
        end

        // Full table of one value with extra loads that must be dropped: largest count,
        // and a miss at the full entry count.
        key = $urandom_range(1, 1000000);
        add_request(OP_CLEAR, 32'sd0);
        for (int i = 0; i < TABLE_DEPTH + 6; i++) add_request(OP_LOAD, key);
        add_request(OP_QUERY, key);
        add_request(OP_QUERY, key + 1);
        add_request(OP_QUERY, key - 1);
        add_request(OP_QUERY, VALUE_MAX);
        add_request(OP_QUERY, VALUE_MIN);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_to_send.size() > 0 || start) @(posedge i_clk);
        while (awaited_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sorted_table_occurrence_counter.f -----
design/sotc_pkg.sv
design/sotc_table.sv
design/sotc_bound.sv
design/sotc_search.sv
design/sorted_table_occurrence_counter.sv
test/tb_sorted_table_occurrence_counter.sv
